[rtl/core/edv_pkg.sv]
package edv_pkg;

	// Width of one angle field, signed, in fractional degree units.
	localparam int ANGLE_W = 13;

	// Fixed-point constants for the series evaluation of the trig table.
	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned PI_Q30  = 64'd3373259426;

	// Load enables for the three stages of one trig lane.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} edv_lane_en_t;

	// Load enables for the two stages of one output row.
	typedef struct packed {
		logic s6;
		logic s7;
	} edv_row_en_t;

endpackage

[rtl/core/edv_trig_lane.sv]
module edv_trig_lane #(
	parameter int TRIG_FRAC_BITS  = 15,
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  logic                                   clk,
	input  edv_pkg::edv_lane_en_t                  en,
	input  logic signed [edv_pkg::ANGLE_W-1:0]     angle,
	output logic signed [TRIG_FRAC_BITS:0]         sin_val,
	output logic signed [TRIG_FRAC_BITS:0]         cos_val
);
	import edv_pkg::*;

	localparam int TF = TRIG_FRAC_BITS;
	localparam int TW = TF + 1;
	localparam longint FULL_TURN    = longint'(360) << ANGLE_FRAC_BITS;
	localparam longint QUARTER_TURN = longint'(90) << ANGLE_FRAC_BITS;
	localparam longint EIGHTH_TURN  = longint'(45) << ANGLE_FRAC_BITS;
	localparam longint unsigned HALF_TURN_U = longint'(180) << ANGLE_FRAC_BITS;
	localparam longint ANG_SPAN     = longint'(1) << (ANGLE_W - 1);
	localparam longint OFFS         = FULL_TURN * ((ANG_SPAN + FULL_TURN - 1) / FULL_TURN);
	localparam int     UW           = $clog2(OFFS + ANG_SPAN);
	localparam longint RECIP        = (longint'(1) << UW) / FULL_TURN;
	localparam int     RW           = $clog2(RECIP + 1);
	localparam longint QMAX         = (OFFS + ANG_SPAN - 1) / FULL_TURN;
	localparam int     QW           = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
	localparam int     FW           = $clog2(FULL_TURN);
	localparam int     DEPTH        = int'(EIGHTH_TURN + 1);
	localparam int     NW           = $clog2(DEPTH);
	localparam int     TRIG_SH      = 30 - TF;

	// Series evaluation, used only to fill the constant tables.
	function automatic longint unsigned ang_q30(input longint unsigned n);
		return (n * PI_Q30) / HALF_TURN_U;
	endfunction

	function automatic longint unsigned sin_q30(input longint unsigned n);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		x  = ang_q30(n);
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		return (x * t) >> 30;
	endfunction

	function automatic longint unsigned cos_q30(input longint unsigned n);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		x  = ang_q30(n);
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 90;
		t  = Q30_ONE - ((x2 * t) >> 30) / 56;
		t  = Q30_ONE - ((x2 * t) >> 30) / 30;
		t  = Q30_ONE - ((x2 * t) >> 30) / 12;
		t  = Q30_ONE - ((x2 * t) >> 30) / 2;
		return t;
	endfunction

	function automatic longint unsigned to_trig(input longint unsigned v);
		longint unsigned r;
		longint unsigned lim;
		r   = (v + (64'd1 << (TRIG_SH - 1))) >> TRIG_SH;
		lim = (64'd1 << TF) - 64'd1;
		return (r > lim) ? lim : r;
	endfunction

	// Constant sine and cosine tables over the first eighth of a turn.
	logic [TF-1:0] sin_rom [DEPTH];
	logic [TF-1:0] cos_rom [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		assign sin_rom[i] = TF'(to_trig(sin_q30(longint'(i))));
		assign cos_rom[i] = TF'(to_trig(cos_q30(longint'(i))));
	end

	// Stage 1: offset the angle to be non-negative and estimate the turn count.
	logic signed [UW:0]      u_wide;
	logic [UW-1:0]           u_c;
	logic [UW+RW-1:0]        q_prod;
	logic [UW-1:0]           u_s1;
	logic [QW-1:0]           q_s1;

	assign u_wide = (UW+1)'(angle) + (UW+1)'(OFFS);
	assign u_c    = u_wide[UW-1:0];
	assign q_prod = (UW+RW)'(u_c) * (UW+RW)'(RECIP);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			u_s1 <= u_c;
			q_s1 <= QW'(q_prod >> UW);
		end
	end

	// Stage 2: finish the reduction, split into quadrant and base angle.
	logic [UW-1:0]   m_full;
	logic [UW-1:0]   m_fix;
	logic [FW-1:0]   m_c;
	logic [FW-1:0]   r_c;
	logic [1:0]      quad_c;
	logic            swap_c;
	logic [NW-1:0]   n_c;
	logic [NW-1:0]   n_s2;
	logic [1:0]      quad_s2;
	logic            swap_s2;

	always_comb begin
		m_full = u_s1 - UW'(UW'(q_s1) * UW'(FULL_TURN));
		m_fix  = (m_full >= UW'(FULL_TURN)) ? m_full - UW'(FULL_TURN) : m_full;
		m_c    = FW'(m_fix);
		priority if (m_c >= FW'(3 * QUARTER_TURN)) begin
			quad_c = 2'd3;
			r_c    = m_c - FW'(3 * QUARTER_TURN);
		end else if (m_c >= FW'(2 * QUARTER_TURN)) begin
			quad_c = 2'd2;
			r_c    = m_c - FW'(2 * QUARTER_TURN);
		end else if (m_c >= FW'(QUARTER_TURN)) begin
			quad_c = 2'd1;
			r_c    = m_c - FW'(QUARTER_TURN);
		end else begin
			quad_c = 2'd0;
			r_c    = m_c;
		end
		swap_c = (r_c > FW'(EIGHTH_TURN));
		n_c    = swap_c ? NW'(FW'(QUARTER_TURN) - r_c) : NW'(r_c);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			n_s2    <= n_c;
			quad_s2 <= quad_c;
			swap_s2 <= swap_c;
		end
	end

	// Stage 3: registered table read.
	logic [TF-1:0] sin_s3;
	logic [TF-1:0] cos_s3;
	logic [1:0]    quad_s3;
	logic          swap_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sin_s3  <= sin_rom[n_s2];
			cos_s3  <= cos_rom[n_s2];
			quad_s3 <= quad_s2;
			swap_s3 <= swap_s2;
		end
	end

	// Undo the octant fold, then map the quadrant onto sine and cosine.
	logic signed [TW-1:0] s0;
	logic signed [TW-1:0] c0;

	always_comb begin
		s0 = swap_s3 ? $signed({1'b0, cos_s3}) : $signed({1'b0, sin_s3});
		c0 = swap_s3 ? $signed({1'b0, sin_s3}) : $signed({1'b0, cos_s3});
		unique case (quad_s3)
			2'd0: begin
				sin_val = s0;
				cos_val = c0;
			end
			2'd1: begin
				sin_val = c0;
				cos_val = -s0;
			end
			2'd2: begin
				sin_val = -s0;
				cos_val = -c0;
			end
			default: begin
				sin_val = -c0;
				cos_val = s0;
			end
		endcase
	end

endmodule

[rtl/core/edv_row.sv]
module edv_row #(
	parameter int COORD_BITS     = 16,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                              clk,
	input  edv_pkg::edv_row_en_t              en,
	input  logic signed [TRIG_FRAC_BITS+2:0]  e0,
	input  logic signed [TRIG_FRAC_BITS+2:0]  e1,
	input  logic signed [TRIG_FRAC_BITS+2:0]  e2,
	input  logic signed [COORD_BITS-1:0]      x,
	input  logic signed [COORD_BITS-1:0]      y,
	input  logic signed [COORD_BITS-1:0]      z,
	output logic signed [COORD_BITS-1:0]      rot,
	output logic                              clip
);
	import edv_pkg::*;

	localparam int EW = TRIG_FRAC_BITS + 3;
	localparam int PW = EW + COORD_BITS;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] HALF_LSB = SW'(64'sd1 <<< (TRIG_FRAC_BITS - 1));
	localparam logic signed [SW-1:0] MAX_V    = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] MIN_V    = SW'(-(64'sd1 <<< (COORD_BITS - 1)));

	// Stage 6: the three entry-by-coordinate products.
	logic signed [PW-1:0] p0_s6;
	logic signed [PW-1:0] p1_s6;
	logic signed [PW-1:0] p2_s6;

	always_ff @(posedge clk) begin
		if (en.s6) begin
			p0_s6 <= PW'(e0) * PW'(x);
			p1_s6 <= PW'(e1) * PW'(y);
			p2_s6 <= PW'(e2) * PW'(z);
		end
	end

	// Stage 7: sum, round to nearest with ties up, and saturate.
	logic signed [SW-1:0] sum_c;
	logic signed [SW-1:0] rnd_c;

	assign sum_c = SW'(p0_s6) + SW'(p1_s6) + SW'(p2_s6) + HALF_LSB;
	assign rnd_c = sum_c >>> TRIG_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en.s7) begin
			priority if (rnd_c > MAX_V) begin
				rot  <= COORD_BITS'(MAX_V);
				clip <= 1'b1;
			end else if (rnd_c < MIN_V) begin
				rot  <= COORD_BITS'(MIN_V);
				clip <= 1'b1;
			end else begin
				rot  <= COORD_BITS'(rnd_c);
				clip <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/euler_dcm_vector_rotate.sv]
// A result is registered through every stage after its input transfer and is offered from the last.
// Throughput: one vector per cycle while the output is not stalled, through seven
// stages: three in each trig lane, two for the matrix products and two in each output row.
// A stalled output holds every full stage back to the nearest bubble; earlier stages keep filling it.
// Reset (arst_n low, asynchronous) empties the pipeline; the data registers are not reset.
module euler_dcm_vector_rotate #(
	parameter int COORD_BITS      = 16,
	parameter int TRIG_FRAC_BITS  = 15,
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_BITS-1:0]        vec_x,
	input  logic signed [COORD_BITS-1:0]        vec_y,
	input  logic signed [COORD_BITS-1:0]        vec_z,
	input  logic signed [edv_pkg::ANGLE_W-1:0]  pitch,
	input  logic signed [edv_pkg::ANGLE_W-1:0]  roll,
	input  logic signed [edv_pkg::ANGLE_W-1:0]  yaw,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS-1:0]        rot_x,
	output logic signed [COORD_BITS-1:0]        rot_y,
	output logic signed [COORD_BITS-1:0]        rot_z,
	output logic                                clipped
);
	import edv_pkg::*;

	localparam int TF     = TRIG_FRAC_BITS;
	localparam int TW     = TF + 1;
	localparam int EW     = TF + 3;
	localparam int STAGES = 7;
	localparam int VSTAGES = 5;
	localparam logic signed [2*TW-1:0] HALF_LSB = (2*TW)'(64'sd1 <<< (TF - 1));
	localparam logic signed [COORD_BITS-1:0] MAX_C = COORD_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 1);
	localparam logic signed [COORD_BITS-1:0] MIN_C = COORD_BITS'(-(64'sd1 <<< (COORD_BITS - 1)));

	// Product of two trig values, rounded back to the trig format.
	function automatic logic signed [TW-1:0] mul2(input logic signed [TW-1:0] a,
	                                              input logic signed [TW-1:0] b);
		logic signed [2*TW-1:0] p;
		p = (2*TW)'(a) * (2*TW)'(b) + HALF_LSB;
		return TW'(p >>> TF);
	endfunction

	// Pipeline occupancy and per-stage load enables.
	logic [STAGES-1:0] stage_valid_q;
	logic [STAGES-1:0] stage_free;

	always_comb begin
		stage_free[STAGES-1] = !stage_valid_q[STAGES-1] || !out_stall;
		for (int k = STAGES - 2; k >= 0; k--) begin
			stage_free[k] = !stage_valid_q[k] || stage_free[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (stage_free[0]) begin
				stage_valid_q[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (stage_free[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !stage_free[0];
	assign out_valid = stage_valid_q[STAGES-1];

	// The vector travels alongside the trig and matrix stages.
	logic signed [COORD_BITS-1:0] vx_s [VSTAGES];
	logic signed [COORD_BITS-1:0] vy_s [VSTAGES];
	logic signed [COORD_BITS-1:0] vz_s [VSTAGES];

	always_ff @(posedge clk) begin
		if (stage_free[0]) begin
			vx_s[0] <= vec_x;
			vy_s[0] <= vec_y;
			vz_s[0] <= vec_z;
		end
		for (int k = 1; k < VSTAGES; k++) begin
			if (stage_free[k]) begin
				vx_s[k] <= vx_s[k-1];
				vy_s[k] <= vy_s[k-1];
				vz_s[k] <= vz_s[k-1];
			end
		end
	end

	// Three trig lanes, one per angle.
	edv_lane_en_t lane_en;
	logic signed [TW-1:0] sp;
	logic signed [TW-1:0] cp;
	logic signed [TW-1:0] sr;
	logic signed [TW-1:0] cr;
	logic signed [TW-1:0] sy;
	logic signed [TW-1:0] cy;

	assign lane_en.s1 = stage_free[0];
	assign lane_en.s2 = stage_free[1];
	assign lane_en.s3 = stage_free[2];

	edv_trig_lane #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_lane_pitch (
		.clk    (clk),
		.en     (lane_en),
		.angle  (pitch),
		.sin_val(sp),
		.cos_val(cp)
	);

	edv_trig_lane #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_lane_roll (
		.clk    (clk),
		.en     (lane_en),
		.angle  (roll),
		.sin_val(sr),
		.cos_val(cr)
	);

	edv_trig_lane #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_lane_yaw (
		.clk    (clk),
		.en     (lane_en),
		.angle  (yaw),
		.sin_val(sy),
		.cos_val(cy)
	);

	// Stage 4: pairwise products of the lane results.
	logic signed [TW-1:0] cr_cy_s4, cr_sy_s4, cp_sy_s4, cp_cy_s4, cr_sp_s4;
	logic signed [TW-1:0] cy_sp_s4, sp_sr_s4, cp_sr_s4, sp_sy_s4, cp_cr_s4;
	logic signed [TW-1:0] sr_s4, sy_s4;

	always_ff @(posedge clk) begin
		if (stage_free[3]) begin
			cr_cy_s4 <= mul2(cr, cy);
			cr_sy_s4 <= mul2(cr, sy);
			cp_sy_s4 <= mul2(cp, sy);
			cp_cy_s4 <= mul2(cp, cy);
			cr_sp_s4 <= mul2(cr, sp);
			cy_sp_s4 <= mul2(cy, sp);
			sp_sr_s4 <= mul2(sp, sr);
			cp_sr_s4 <= mul2(cp, sr);
			sp_sy_s4 <= mul2(sp, sy);
			cp_cr_s4 <= mul2(cp, cr);
			sr_s4    <= sr;
			sy_s4    <= sy;
		end
	end

	// Stage 5: triple products and the nine matrix entries.
	logic signed [EW-1:0] e00_s5, e01_s5, e02_s5;
	logic signed [EW-1:0] e10_s5, e11_s5, e12_s5;
	logic signed [EW-1:0] e20_s5, e21_s5, e22_s5;

	always_ff @(posedge clk) begin
		if (stage_free[4]) begin
			e00_s5 <= EW'(cr_cy_s4);
			e01_s5 <= EW'(cr_sy_s4);
			e02_s5 <= -EW'(sr_s4);
			e10_s5 <= EW'(mul2(cy_sp_s4, sr_s4)) - EW'(cp_sy_s4);
			e11_s5 <= EW'(mul2(sp_sr_s4, sy_s4)) + EW'(cp_cy_s4);
			e12_s5 <= EW'(cr_sp_s4);
			e20_s5 <= EW'(mul2(cp_cy_s4, sr_s4)) + EW'(sp_sy_s4);
			e21_s5 <= EW'(mul2(cp_sr_s4, sy_s4)) - EW'(cy_sp_s4);
			e22_s5 <= EW'(cp_cr_s4);
		end
	end

	// Three output rows, merged into the result.
	edv_row_en_t row_en;
	logic clip_x, clip_y, clip_z;

	assign row_en.s6 = stage_free[5];
	assign row_en.s7 = stage_free[6];

	edv_row #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_row_x (
		.clk(clk), .en(row_en),
		.e0(e00_s5), .e1(e01_s5), .e2(e02_s5),
		.x(vx_s[VSTAGES-1]), .y(vy_s[VSTAGES-1]), .z(vz_s[VSTAGES-1]),
		.rot(rot_x), .clip(clip_x)
	);

	edv_row #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_row_y (
		.clk(clk), .en(row_en),
		.e0(e10_s5), .e1(e11_s5), .e2(e12_s5),
		.x(vx_s[VSTAGES-1]), .y(vy_s[VSTAGES-1]), .z(vz_s[VSTAGES-1]),
		.rot(rot_y), .clip(clip_y)
	);

	edv_row #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_row_z (
		.clk(clk), .en(row_en),
		.e0(e20_s5), .e1(e21_s5), .e2(e22_s5),
		.x(vx_s[VSTAGES-1]), .y(vy_s[VSTAGES-1]), .z(vz_s[VSTAGES-1]),
		.rot(rot_z), .clip(clip_z)
	);

	assign clipped = clip_x | clip_y | clip_z;

	// The input is held back only when the output stage is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// A full pipeline behind a blocked output must stall the input.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((&stage_valid_q) && out_stall) |-> in_stall)
		else $error("full pipeline accepted another transfer");

	// A result only leaves after its transfer.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped without a transfer");

	// A clipped result carries at least one coordinate at a limit.
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |-> (rot_x == MAX_C || rot_x == MIN_C ||
			rot_y == MAX_C || rot_y == MIN_C || rot_z == MAX_C || rot_z == MIN_C))
		else $error("clip flag without a saturated coordinate");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

	localparam int COORD_W   = 16;
	localparam int TRIG_FRAC = 15;
	localparam int ANG_FRAC  = 4;
	localparam int ANG_W     = edv_pkg::ANGLE_W;
	localparam int N_RANDOM  = 1500;
	localparam int N_CALM    = 200;
	localparam int LATENCY   = 7;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam longint FULL_TURN    = 360 << ANG_FRAC;
	localparam longint QUARTER_TURN = 90 << ANG_FRAC;
	localparam longint EIGHTH_TURN  = 45 << ANG_FRAC;
	localparam longint HALF_TURN    = 180 << ANG_FRAC;
	localparam longint unsigned Q1  = edv_pkg::Q30_ONE;

	typedef struct {
		logic signed [COORD_W-1:0] x, y, z;
		logic signed [ANG_W-1:0]   p, r, w;
	} pose_t;

	typedef struct {
		logic signed [COORD_W-1:0] x, y, z;
		logic                      clip;
	} rotated_t;

	typedef struct {
		pose_t    pose;
		bit       known;
		rotated_t want;
	} pose_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_W-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic signed [ANG_W-1:0] pitch = '0, roll = '0, yaw = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_W-1:0] rot_x, rot_y, rot_z;
	logic clipped;

	rotated_t rotated_q[$];
	pose_row_t pose_rows[$];
	int errors = 0;
	int n_sent = 0;
	int n_recv = 0;
	int n_clipped = 0;
	int idle_count = 0;
	bit calm = 1'b0;

	euler_dcm_vector_rotate uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.pitch(pitch), .roll(roll), .yaw(yaw),
		.out_valid(out_valid), .out_stall(out_stall),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .clipped(clipped)
	);

	// Clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Series evaluation of sine and cosine in Q30 for a base angle up to 45 degrees.
	function automatic longint unsigned series_sin(longint unsigned n);
		longint unsigned a, a2, t;
		a = (n * edv_pkg::PI_Q30) / HALF_TURN;
		a2 = (a * a) >> 30;
		t = Q1 - a2 / 72;
		t = Q1 - ((a2 * t) >> 30) / 42;
		t = Q1 - ((a2 * t) >> 30) / 20;
		t = Q1 - ((a2 * t) >> 30) / 6;
		return (a * t) >> 30;
	endfunction

	function automatic longint unsigned series_cos(longint unsigned n);
		longint unsigned a, a2, t;
		a = (n * edv_pkg::PI_Q30) / HALF_TURN;
		a2 = (a * a) >> 30;
		t = Q1 - a2 / 90;
		t = Q1 - ((a2 * t) >> 30) / 56;
		t = Q1 - ((a2 * t) >> 30) / 30;
		t = Q1 - ((a2 * t) >> 30) / 12;
		t = Q1 - ((a2 * t) >> 30) / 2;
		return t;
	endfunction

	// Rounds a Q30 value to the trig format and limits it just below one.
	function automatic longint q30_to_trig(longint unsigned v);
		longint unsigned rv;
		rv = (v + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
		if (rv > (64'd1 << TRIG_FRAC) - 1)
			rv = (64'd1 << TRIG_FRAC) - 1;
		return longint'(rv);
	endfunction

	// Sine and cosine of a signed angle, by quadrant and octant.
	function automatic void trig_of(input longint ang, output longint s, output longint c);
		longint m, q, rem, s0, c0;
		m = ang % FULL_TURN;
		if (m < 0)
			m += FULL_TURN;
		q = m / QUARTER_TURN;
		rem = m % QUARTER_TURN;
		if (rem <= EIGHTH_TURN) begin
			s0 = q30_to_trig(series_sin(rem));
			c0 = q30_to_trig(series_cos(rem));
		end else begin
			s0 = q30_to_trig(series_cos(QUARTER_TURN - rem));
			c0 = q30_to_trig(series_sin(QUARTER_TURN - rem));
		end
		case (q)
			0: begin s = s0; c = c0; end
			1: begin s = c0; c = -s0; end
			2: begin s = -s0; c = -c0; end
			default: begin s = -c0; c = s0; end
		endcase
	endfunction

	function automatic longint tmul(longint a, longint b);
		return (a * b + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
	endfunction

	// One output row: weighted sum, rounded, then saturated.
	function automatic void row_sum(input longint e0, e1, e2, input pose_t ps,
			output logic signed [COORD_W-1:0] res, inout logic clip);
		longint v, hi, lo;
		hi = (64'sd1 <<< (COORD_W - 1)) - 1;
		lo = -hi - 1;
		v = e0 * longint'(ps.x) + e1 * longint'(ps.y) + e2 * longint'(ps.z);
		v = (v + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
		if (v > hi) begin v = hi; clip = 1'b1; end
		if (v < lo) begin v = lo; clip = 1'b1; end
		res = v[COORD_W-1:0];
	endfunction

	function automatic rotated_t rotate_pose(pose_t ps);
		rotated_t o;
		longint sp, cp, sr, cr, sy, cy;
		trig_of(longint'(ps.p), sp, cp);
		trig_of(longint'(ps.r), sr, cr);
		trig_of(longint'(ps.w), sy, cy);
		o.clip = 1'b0;
		row_sum(tmul(cr, cy), tmul(cr, sy), -sr, ps, o.x, o.clip);
		row_sum(tmul(tmul(cy, sp), sr) - tmul(cp, sy),
			tmul(tmul(sp, sr), sy) + tmul(cp, cy), tmul(cr, sp), ps, o.y, o.clip);
		row_sum(tmul(tmul(cp, cy), sr) + tmul(sp, sy),
			tmul(tmul(cp, sr), sy) - tmul(cy, sp), tmul(cp, cr), ps, o.z, o.clip);
		return o;
	endfunction

	task automatic add_row(input int x, y, z, p, r, w, input bit known);
		pose_row_t pr;
		pr.pose.x = COORD_W'(x); pr.pose.y = COORD_W'(y); pr.pose.z = COORD_W'(z);
		pr.pose.p = ANG_W'(p); pr.pose.r = ANG_W'(r); pr.pose.w = ANG_W'(w);
		pr.known = known;
		pr.want = '{x: '0, y: '0, z: '0, clip: 1'b0};
		pose_rows.push_back(pr);
	endtask

	// Expectation for every input transfer; typed rows carry their own.
	pose_row_t cur_row;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			if (cur_row.known)
				rotated_q.push_back(cur_row.want);
			else
				rotated_q.push_back(rotate_pose(cur_row.pose));
		end
	end

	// Output check against the oldest expectation.
	always @(posedge clk) begin
		rotated_t w;
		if (out_valid && !out_stall) begin
			n_recv++;
			if (clipped)
				n_clipped++;
			if (rotated_q.size() == 0) begin
				$error("unexpected output transfer");
				errors++;
			end else begin
				w = rotated_q.pop_front();
				if (rot_x !== w.x) begin
					$error("rot_x expected %0d actual %0d", w.x, rot_x); errors++;
				end
				if (rot_y !== w.y) begin
					$error("rot_y expected %0d actual %0d", w.y, rot_y); errors++;
				end
				if (rot_z !== w.z) begin
					$error("rot_z expected %0d actual %0d", w.z, rot_z); errors++;
				end
				if (clipped !== w.clip) begin
					$error("clipped expected %0d actual %0d", w.clip, clipped); errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_count = 0;
		else if (arst_n && ++idle_count >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver stall: random bursts, one long hold-off, none at the end.
	initial begin
		bit held;
		int len;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				out_stall <= 1'b0;
			end else if (!held && n_recv >= 400) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				len = $urandom_range(1, 16);
				out_stall <= 1'b1;
				repeat (len) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one pose and holds it until the transfer.
	task automatic send_pose(input pose_row_t pr, input bit gaps);
		int len;
		if (gaps && $urandom_range(0, 5) == 0) begin
			len = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (len) @(negedge clk);
		end
		cur_row = pr;
		vec_x <= pr.pose.x; vec_y <= pr.pose.y; vec_z <= pr.pose.z;
		pitch <= pr.pose.p; roll <= pr.pose.r; yaw <= pr.pose.w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_sent++;
		@(negedge clk);
	endtask

	function automatic int rand_angle();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 8) * 360 - 1440 + $urandom_range(0, 2) - 1;
			default: return int'($urandom_range(0, 5760)) - 2880;
		endcase
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 32767 : -32768;
			1: return int'($urandom_range(0, 400)) - 200;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// Stimulus: directed table, then random poses.
	initial begin
		pose_row_t pr;
		// Zero vector: the output is zero whatever the angles.
		add_row(0, 0, 0, 2880, -2880, 1440, 1'b1);
		add_row(0, 0, 0, -2880, 4095 - 4095, -1, 1'b1);
		// Coordinate extremes at zero and right angles.
		add_row(32767, 32767, 32767, 0, 0, 0, 1'b0);
		add_row(-32768, -32768, -32768, 0, 0, 0, 1'b0);
		add_row(32767, -32768, 32767, 1440, 1440, 1440, 1'b0);
		add_row(-32768, 32767, -32768, -1440, -1440, -1440, 1'b0);
		// Half turns in both senses.
		add_row(12345, -23456, 30000, 2880, -2880, 2880, 1'b0);
		add_row(1, -1, 1, -2880, 2880, -2880, 1'b0);
		// Angles beyond half a turn, up to the ends of the field.
		add_row(1000, -2000, 3000, 4095, -4096, 3000, 1'b0);
		add_row(-32768, 32767, 20000, -3000, 4000, -4096, 1'b0);
		// Either side of the octant switch and quadrant boundaries.
		add_row(20000, 10000, -5000, 720, 719, 721, 1'b0);
		add_row(-20000, 10000, 5000, 1439, 1441, 2159, 1'b0);
		add_row(30000, -30000, 30000, 2160, 2161, -721, 1'b0);
		// Diagonal angles where saturation is likely.
		add_row(32767, 32767, 32767, 720, 720, 720, 1'b0);
		add_row(-32768, -32768, -32768, -720, 720, -720, 1'b0);
		add_row(32767, 32767, -32768, 2160, -2160, 720, 1'b0);
		// Unit axes with small angles.
		add_row(1, 0, 0, 1, 1, 1, 1'b0);
		add_row(0, 1, 0, -1, 16, -16, 1'b0);
		add_row(0, 0, 1, 160, -160, 800, 1'b0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (pose_rows[i])
			send_pose(pose_rows[i], 1'b1);

		for (int i = 0; i < N_RANDOM; i++) begin
			pr.known = 1'b0;
			pr.want = '{x: '0, y: '0, z: '0, clip: 1'b0};
			pr.pose.x = COORD_W'(rand_coord());
			pr.pose.y = COORD_W'(rand_coord());
			pr.pose.z = COORD_W'(rand_coord());
			pr.pose.p = ANG_W'(rand_angle());
			pr.pose.r = ANG_W'(rand_angle());
			pr.pose.w = ANG_W'(rand_angle());
			// Sender pause until the pipeline has drained.
			if (i == N_RANDOM / 3) begin
				in_valid <= 1'b0;
				while (rotated_q.size() != 0) @(negedge clk);
			end
			if (i == N_RANDOM - N_CALM)
				calm = 1'b1;
			send_pose(pr, !calm);
		end
		in_valid <= 1'b0;

		while (rotated_q.size() != 0) @(posedge clk);
		repeat (LATENCY * 3) @(posedge clk);

		$display("Sent %0d poses, checked %0d rotated vectors, %0d of them saturated.",
			n_sent, n_recv, n_clipped);
		if (errors == 0 && rotated_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
